// ----- rtl/utf8_to_utf16le_transcoder_defines.svh -----
// Assertion macros shared by the transcoder RTL.
`ifndef UTF8_TO_UTF16LE_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16LE_TRANSCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// cond must never hold outside reset
`define U8U16_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("assertion failed: condition must never hold");

// ante at an edge requires cons at the same edge
`define U8U16_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication violated");

// ante at an edge requires cons at the next edge
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication violated");

`else

`define U8U16_ASSERT_NEVER(label, clk, rst_n, cond)
`define U8U16_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/u8u16_pkg.sv -----
package u8u16_pkg;

	localparam int unsigned CP_W   = 21;
	localparam int unsigned UNIT_W = 16;

	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD2_BITS = 8'h1F;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD3_BITS = 8'h0F;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;
	localparam logic [7:0] LEAD4_BITS = 8'h07;

	localparam logic [CP_W-1:0]   SUPP_BASE = 21'h10000;
	localparam logic [UNIT_W-1:0] HI_SURR   = 16'hD800;
	localparam logic [UNIT_W-1:0] LO_SURR   = 16'hDC00;

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;
	localparam logic [1:0] PEND_THREE = 2'd3;

	// byte positions within a queued code point
	localparam logic [1:0] BYTE_U0_LO = 2'd0;
	localparam logic [1:0] BYTE_U0_HI = 2'd1;
	localparam logic [1:0] BYTE_U1_LO = 2'd2;
	localparam logic [1:0] BYTE_U1_HI = 2'd3;

	typedef struct packed {
		logic [UNIT_W-1:0] unit0;
		logic [UNIT_W-1:0] unit1;
		logic              pair;
		logic              done;
	} cp_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

// ----- rtl/utf8_to_utf16le_transcoder.sv -----
// UTF-8 to UTF-16LE transcoder.
// Input channel: in_valid / in_stall carry one UTF-8 byte (in_byte) and a
// string_end flag on the last byte of a string; a transfer happens at an edge
// with in_valid high and in_stall low. One byte can be taken every cycle while the queue is not full.
// The decoder front end assembles code points and pushes finished ones
// (already split into one or two UTF-16 units) into a DEPTH-entry queue.
// Output channel: out_valid / out_stall carry out_byte, low byte of each unit
// first, with run_last on the last byte a given input produced and
// string_done on the last byte of a string.
// The byte that completes a code point is pushed into the queue; the entry
// then moves to the serializer's current register, its first byte to the
// output register. The serializer sends one byte per cycle while out_stall is
// low; each code point gives 2 or 4 bytes. When the output is the bottleneck
// the queue fills and in_stall rises. A stalled output holds its byte; the
// front keeps accepting until the queue is full.
// Reset clears the accumulator, empties the queue and clears out_valid; no
// partial sequence survives it.
`include "utf8_to_utf16le_transcoder_defines.svh"

module utf8_to_utf16le_transcoder #(
	parameter int unsigned DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       string_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       string_done
);
	import u8u16_pkg::*;

	cp_entry_t    push_data;
	cp_entry_t    head;
	fifo_status_t status;
	logic         push;
	logic         pop;

	u8u16_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.string_end(string_end),
		.status    (status),
		.push      (push),
		.push_data (push_data)
	);

	u8u16_fifo #(
		.DEPTH(DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.status   (status)
	);

	u8u16_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.status     (status),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_done(string_done)
	);

	`U8U16_ASSERT_NEVER(a_no_push_full, clk, arst_n, push && status.full)
	`U8U16_ASSERT_NEVER(a_status_sane, clk, arst_n, status.full && status.empty)
	`U8U16_ASSERT_IMPLY(a_done_is_last, clk, arst_n, out_valid && string_done, run_last)
	`U8U16_ASSERT_NEXT(a_push_fills, clk, arst_n, push && !pop, !status.empty)

endmodule

// ----- rtl/u8u16_front.sv -----
module u8u16_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [7:0]              in_byte,
	input  logic                    string_end,
	input  u8u16_pkg::fifo_status_t status,
	output logic                    push,
	output u8u16_pkg::cp_entry_t    push_data
);
	import u8u16_pkg::*;

	logic [CP_W-1:0]   accum_q;
	logic [1:0]        pend_q;
	logic [CP_W-1:0]   accum_next;
	logic [1:0]        pend_next;
	logic              accept;
	logic              emit;
	logic              big;
	logic [CP_W-1:0]   offs;

	assign in_stall = status.full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		if (pend_q == PEND_NONE) begin
			if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
				accum_next = {13'd0, in_byte & LEAD2_BITS};
				pend_next  = PEND_ONE;
			end else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) begin
				accum_next = {13'd0, in_byte & LEAD3_BITS};
				pend_next  = PEND_TWO;
			end else if ((in_byte & LEAD4_MASK) == LEAD4_CODE) begin
				accum_next = {13'd0, in_byte & LEAD4_BITS};
				pend_next  = PEND_THREE;
			end else begin
				accum_next = {13'd0, in_byte};
				pend_next  = PEND_NONE;
			end
		end else begin
			// continuation form is not checked
			accum_next = {accum_q[CP_W-7:0], in_byte[5:0]};
			pend_next  = pend_q - 2'd1;
		end
	end

	assign emit = (pend_next == PEND_NONE) || string_end;
	assign push = accept && emit;

	assign big  = accum_next[CP_W-1:UNIT_W] != '0;
	assign offs = accum_next - SUPP_BASE;

	always_comb begin
		push_data.pair = big;
		push_data.done = string_end;
		if (big) begin
			push_data.unit0 = HI_SURR + {5'd0, offs[CP_W-1:10]};
			push_data.unit1 = LO_SURR + {6'd0, offs[9:0]};
		end else begin
			push_data.unit0 = accum_next[UNIT_W-1:0];
			push_data.unit1 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			pend_q  <= PEND_NONE;
		end else if (accept) begin
			if (emit) begin
				accum_q <= '0;
				pend_q  <= PEND_NONE;
			end else begin
				accum_q <= accum_next;
				pend_q  <= pend_next;
			end
		end
	end

endmodule

// ----- rtl/u8u16_fifo.sv -----
module u8u16_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  u8u16_pkg::cp_entry_t    push_data,
	input  logic                    pop,
	output u8u16_pkg::cp_entry_t    head,
	output u8u16_pkg::fifo_status_t status
);
	import u8u16_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cp_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = count_q == FULL_CNT;
	assign status.empty = count_q == '0;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/u8u16_back.sv -----
module u8u16_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  u8u16_pkg::cp_entry_t    head,
	input  u8u16_pkg::fifo_status_t status,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [7:0]              out_byte,
	output logic                    run_last,
	output logic                    string_done
);
	import u8u16_pkg::*;

	cp_entry_t   cur_q;
	logic        cur_valid_q;
	logic [1:0]  idx_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        run_last_q;
	logic        string_done_q;
	logic        advance;
	logic        is_last;
	logic [7:0]  sel_byte;

	assign advance = cur_valid_q && (!out_valid_q || !out_stall);
	assign is_last = idx_q == (cur_q.pair ? BYTE_U1_HI : BYTE_U0_HI);
	assign pop     = !status.empty && (!cur_valid_q || (advance && is_last));

	always_comb begin
		case (idx_q)
			BYTE_U0_LO: sel_byte = cur_q.unit0[7:0];
			BYTE_U0_HI: sel_byte = cur_q.unit0[15:8];
			BYTE_U1_LO: sel_byte = cur_q.unit1[7:0];
			BYTE_U1_HI: sel_byte = cur_q.unit1[15:8];
			default:    sel_byte = cur_q.unit0[7:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (advance) begin
			out_byte_q    <= sel_byte;
			run_last_q    <= is_last;
			string_done_q <= is_last && cur_q.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= BYTE_U0_LO;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= BYTE_U0_LO;
			end else if (advance) begin
				if (is_last) begin
					cur_valid_q <= 1'b0;
					idx_q       <= BYTE_U0_LO;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign run_last    = run_last_q;
	assign string_done = string_done_q;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import u8u16_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 220;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       string_end;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_done;

	int cycle_count = 0;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} utf8_item_t;

	utf8_item_t utf8_stream[$];

	// Expected UTF-16LE byte stream, built from the accepted UTF-8 bytes.
	class utf16_scoreboard;
		typedef struct {
			logic [7:0] data;
			logic       unit_last;
			logic       str_done;
		} utf16_byte_t;

		utf16_byte_t     expected_utf16[$];
		logic [CP_W-1:0] code_point;
		logic [1:0]      cont_left;
		int              err_count;

		function new();
			code_point = '0;
			cont_left  = PEND_NONE;
			err_count  = 0;
		endfunction

		function void push_unit(logic [UNIT_W-1:0] unit, logic unit_last, logic str_done);
			utf16_byte_t lo_b;
			utf16_byte_t hi_b;
			lo_b.data      = unit[7:0];
			lo_b.unit_last = 1'b0;
			lo_b.str_done  = 1'b0;
			hi_b.data      = unit[15:8];
			hi_b.unit_last = unit_last;
			hi_b.str_done  = unit_last & str_done;
			expected_utf16.insert(expected_utf16.size(), lo_b);
			expected_utf16.insert(expected_utf16.size(), hi_b);
		endfunction

		// called for each accepted input transfer
		function void note_utf8_byte(logic [7:0] b, logic last);
			logic [CP_W-1:0]   cp;
			logic [CP_W-1:0]   offs;
			logic [UNIT_W-1:0] hi_unit;
			logic [UNIT_W-1:0] lo_unit;
			if (cont_left == PEND_NONE) begin
				if ((b & LEAD2_MASK) == LEAD2_CODE) begin
					code_point = CP_W'(b & LEAD2_BITS);
					cont_left  = PEND_ONE;
				end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
					code_point = CP_W'(b & LEAD3_BITS);
					cont_left  = PEND_TWO;
				end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
					code_point = CP_W'(b & LEAD4_BITS);
					cont_left  = PEND_THREE;
				end else begin
					code_point = CP_W'(b);
					cont_left  = PEND_NONE;
				end
			end else begin
				// continuation form is never checked
				code_point = {code_point[CP_W-7:0], b[5:0]};
				cont_left  = cont_left - 2'd1;
			end
			if (cont_left != PEND_NONE && !last)
				return;
			cp         = code_point;
			code_point = '0;
			cont_left  = PEND_NONE;
			if (cp <= CP_W'(21'h0FFFF)) begin
				push_unit(cp[UNIT_W-1:0], 1'b1, last);
			end else begin
				offs    = cp - SUPP_BASE;
				hi_unit = HI_SURR + UNIT_W'(offs >> 10);
				lo_unit = LO_SURR + UNIT_W'(offs[9:0]);
				push_unit(hi_unit, 1'b0, 1'b0);
				push_unit(lo_unit, 1'b1, last);
			end
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			err_count++;
		endtask

		task check_utf16_byte(logic [7:0] data, logic unit_last, logic str_done);
			utf16_byte_t exp_b;
			if (expected_utf16.size() == 0) begin
				report($sformatf("unexpected output byte %02h", data));
				return;
			end
			exp_b = expected_utf16.pop_front();
			if (data !== exp_b.data)
				report($sformatf("out_byte %02h, expected %02h", data, exp_b.data));
			if (unit_last !== exp_b.unit_last)
				report($sformatf("run_last %b, expected %b (byte %02h)",
					unit_last, exp_b.unit_last, exp_b.data));
			if (str_done !== exp_b.str_done)
				report($sformatf("string_done %b, expected %b (byte %02h)",
					str_done, exp_b.str_done, exp_b.data));
		endtask
	endclass

	utf16_scoreboard sb = new();

	utf8_to_utf16le_transcoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.string_end  (string_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.string_done (string_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic void add_byte(logic [7:0] b, logic last);
		utf8_item_t it;
		it.data = b;
		it.last = last;
		utf8_stream.insert(utf8_stream.size(), it);
	endfunction

	function automatic logic [7:0] lead_byte(int n_cont);
		case (n_cont)
			1: lead_byte = LEAD2_CODE | (8'($urandom) & LEAD2_BITS);
			2: lead_byte = LEAD3_CODE | (8'($urandom) & LEAD3_BITS);
			default: lead_byte = LEAD4_CODE | (8'($urandom) & LEAD4_BITS);
		endcase
	endfunction

	function automatic logic [7:0] cont_byte();
		if ($urandom_range(0, 7) == 0)
			cont_byte = 8'($urandom);
		else
			cont_byte = {2'b10, 6'($urandom)};
	endfunction

	function automatic void add_directed();
		add_byte(8'h00, 1'b0);
		add_byte(8'h7F, 1'b0);
		add_byte(8'hC2, 1'b0); add_byte(8'hA9, 1'b0);
		add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'hAC, 1'b0);
		add_byte(8'hF0, 1'b0); add_byte(8'h9F, 1'b0); add_byte(8'h98, 1'b0);
		add_byte(8'h80, 1'b0);
		// stray continuation and invalid leads pass through as their own value
		add_byte(8'h80, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hF8, 1'b0);
		// lead-like byte inside a sequence; yields the largest 21-bit code point
		add_byte(8'hF7, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hBF, 1'b0);
		add_byte(8'hBF, 1'b0);
		// truncated sequence, then a lone lead, at string end
		add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b1);
		add_byte(8'hF4, 1'b1);
		add_byte(8'hC3, 1'b0); add_byte(8'hE9, 1'b0);
		add_byte(8'h41, 1'b1);
	endfunction

	function automatic void add_random_sequence();
		logic [7:0] seq[$];
		int         kind;
		int         n_cont;
		int         bad_pos;
		logic       trunc;
		kind  = $urandom_range(0, 9);
		trunc = 1'b0;
		case (kind)
			0, 1: seq.insert(seq.size(), 8'($urandom_range(0, 127)));
			2, 3, 4, 5: begin
				n_cont = (kind == 5) ? 3 : kind - 1;
				seq.insert(seq.size(), lead_byte(n_cont));
				repeat (n_cont) seq.insert(seq.size(), cont_byte());
			end
			6: begin
				if ($urandom_range(0, 1))
					seq.insert(seq.size(), 8'($urandom_range(128, 191)));
				else
					seq.insert(seq.size(), 8'($urandom_range(248, 255)));
			end
			7: begin
				n_cont = $urandom_range(1, 3);
				trunc  = 1'b1;
				seq.insert(seq.size(), lead_byte(n_cont));
				repeat ($urandom_range(0, n_cont - 1)) seq.insert(seq.size(), cont_byte());
			end
			8: begin
				n_cont  = $urandom_range(1, 3);
				bad_pos = $urandom_range(1, n_cont);
				seq.insert(seq.size(), lead_byte(n_cont));
				for (int i = 1; i <= n_cont; i++)
					seq.insert(seq.size(),
						i == bad_pos ? 8'($urandom_range(192, 255)) : cont_byte());
			end
			default: seq.insert(seq.size(), 8'($urandom));
		endcase
		foreach (seq[i])
			add_byte(seq[i], (i == seq.size() - 1) &&
				(trunc || $urandom_range(0, 3) == 0));
	endfunction

	task automatic send_utf8_byte(utf8_item_t it, int gap);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		in_byte    <= it.data;
		string_end <= it.last;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		sb.note_utf8_byte(it.data, it.last);
	endtask

	// output side: random stall before each transfer, with bursts of none
	initial begin
		bit no_wait;
		int gap;
		no_wait   = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				no_wait = !no_wait;
			gap = no_wait ? 0 : $urandom_range(0, 11);
			repeat (gap) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(out_valid && !out_stall));
			sb.check_utf16_byte(out_byte, run_last, string_done);
		end
	end

	initial begin
		bit no_wait;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_byte    = 8'h00;
		string_end = 1'b0;
		no_wait    = 1'b0;
		add_directed();
		while (utf8_stream.size() < RANDOM_ITEMS)
			add_random_sequence();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		foreach (utf8_stream[i]) begin
			if ($urandom_range(0, 15) == 0)
				no_wait = !no_wait;
			send_utf8_byte(utf8_stream[i], no_wait ? 0 : $urandom_range(0, 11));
		end
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_utf16.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- utf8_to_utf16le_transcoder.f -----
+incdir+rtl
rtl/u8u16_pkg.sv
rtl/u8u16_front.sv
rtl/u8u16_fifo.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16le_transcoder.sv
verif/tb_top.sv
